[src/wfba_pkg.sv]
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared types and constants for the worst-fit block allocator.
// ----------------------------------------------------------------------------
package wfba_pkg;

    // default configuration
    localparam int MAX_BLOCKS_DEF = 32;
    localparam int SIZE_BITS_DEF  = 16;

    // fixed port field widths
    localparam int AMOUNT_W = 16;
    localparam int POS_W    = 5;
    localparam int SUM_W    = 21;
    localparam int COUNT_W  = 6;

    // widths that cover every legal parameter value
    localparam int IDX_MAX_W  = 8;   // up to 256 blocks
    localparam int CNT_MAX_W  = 9;   // counts up to 256
    localparam int SIZE_MAX_W = 32;  // up to 32-bit sizes

    // item modes
    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_ALLOC  = 1'b1;

    // input word
    typedef struct packed {
        logic                mode;
        logic [AMOUNT_W-1:0] amount;
        logic                used_flag;
    } t_in_word;

    // output word
    typedef struct packed {
        logic                granted;
        logic [POS_W-1:0]    position;
        logic [AMOUNT_W-1:0] chosen_size;
        logic [SUM_W-1:0]    free_total;
        logic [COUNT_W-1:0]  entry_count;
        logic                overflow;
    } t_out_word;

    // command broadcast to every table cell
    typedef struct packed {
        logic                  append;     // write the new block at index count
        logic                  alloc_hit;  // mark block best as used
        logic                  split;      // shrink best, insert remainder, shift up
        logic [IDX_MAX_W-1:0]  best;
        logic [CNT_MAX_W-1:0]  count;
        logic [SIZE_MAX_W-1:0] amount;
        logic [SIZE_MAX_W-1:0] rem;
        logic                  used_flag;
    } t_cell_cmd;

endpackage

[src/wfba_cell.sv]
// ----------------------------------------------------------------------------
// wfba_cell
// One table entry: holds a block size and used mark, flags itself as a
// search candidate, and takes its lower neighbor's entry on an insert.
// ----------------------------------------------------------------------------
module wfba_cell #(
    parameter int SIZE_W = wfba_pkg::SIZE_BITS_DEF,
    parameter int POS    = 0
) (
    input  logic                i_clk,
    input  wfba_pkg::t_cell_cmd i_cmd,
    input  logic                i_cmd_en,
    input  logic [SIZE_W-1:0]   i_prev_size,
    input  logic                i_prev_used,
    output logic [SIZE_W-1:0]   o_size,
    output logic                o_used,
    output logic                o_cand
);

    localparam int PW = wfba_pkg::IDX_MAX_W + 1;

    logic [SIZE_W-1:0] r_size;
    logic              r_used;
    logic [SIZE_W-1:0] w_amount;
    logic [SIZE_W-1:0] w_rem;
    logic              w_in_table;
    logic [PW-1:0]     w_pos;
    logic [PW-1:0]     w_best;
    logic [PW-1:0]     w_best_p1;

    assign w_amount   = i_cmd.amount[SIZE_W-1:0];
    assign w_rem      = i_cmd.rem[SIZE_W-1:0];
    assign w_in_table = wfba_pkg::CNT_MAX_W'(POS) < i_cmd.count;
    assign w_pos      = PW'(POS);
    assign w_best     = PW'(i_cmd.best);
    assign w_best_p1  = w_best + PW'(1);

    // free entry large enough for the request
    assign o_cand = w_in_table && !r_used && (r_size >= w_amount);
    assign o_size = r_size;
    assign o_used = r_used;

    // entry update; contents are undefined until written
    always_ff @(posedge i_clk) begin
        if (i_cmd_en) begin
            if (i_cmd.append && (wfba_pkg::CNT_MAX_W'(POS) == i_cmd.count)) begin
                r_size <= w_amount;
                r_used <= i_cmd.used_flag;
            end else if (i_cmd.alloc_hit && (w_pos == w_best)) begin
                r_used <= 1'b1;
                if (i_cmd.split) begin
                    r_size <= w_amount;
                end
            end else if (i_cmd.split && (w_pos == w_best_p1)) begin
                r_size <= w_rem;
                r_used <= 1'b0;
            end else if (i_cmd.split && (w_pos > w_best_p1)) begin
                r_size <= i_prev_size;
                r_used <= i_prev_used;
            end
        end
    end

endmodule

[src/wfba_max_tree.sv]
// ----------------------------------------------------------------------------
// wfba_max_tree
// Registered compare tree: finds the largest candidate size, lowest index
// winning ties. Every tree level is registered, from the leaves to the root.
// ----------------------------------------------------------------------------
module wfba_max_tree #(
    parameter int N      = wfba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_W = wfba_pkg::SIZE_BITS_DEF,
    parameter int IDX_W  = $clog2(N)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cand [N],
    input  logic [SIZE_W-1:0] i_size [N],
    output logic              o_found,
    output logic [IDX_W-1:0]  o_idx,
    output logic [SIZE_W-1:0] o_size
);

    localparam int P = 1 << IDX_W;

    // heap layout: node 1 is the root, leaves sit at P .. 2P-1
    logic              r_vld [1:P-1];
    logic [SIZE_W-1:0] r_sz  [1:P-1];
    logic [IDX_W-1:0]  r_idx [1:P-1];
    logic              w_vld [1:2*P-1];
    logic [SIZE_W-1:0] w_sz  [1:2*P-1];
    logic [IDX_W-1:0]  w_idx [1:2*P-1];

    // internal nodes come from registers
    for (genvar g = 1; g < P; g++) begin : g_node
        assign w_vld[g] = r_vld[g];
        assign w_sz[g]  = r_sz[g];
        assign w_idx[g] = r_idx[g];
    end

    // leaves come from the cells; padding leaves never win
    for (genvar j = 0; j < P; j++) begin : g_leaf
        if (j < N) begin : g_real
            assign w_vld[P+j] = i_cand[j];
            assign w_sz[P+j]  = i_size[j];
        end else begin : g_pad
            assign w_vld[P+j] = 1'b0;
            assign w_sz[P+j]  = '0;
        end
        assign w_idx[P+j] = IDX_W'(j);
    end

    // every node picks the better child; left (lower index) on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i < P; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            for (int i = 1; i < P; i++) begin
                if (w_vld[2*i] && (!w_vld[2*i+1] || (w_sz[2*i] >= w_sz[2*i+1]))) begin
                    r_vld[i] <= w_vld[2*i];
                    r_sz[i]  <= w_sz[2*i];
                    r_idx[i] <= w_idx[2*i];
                end else begin
                    r_vld[i] <= w_vld[2*i+1];
                    r_sz[i]  <= w_sz[2*i+1];
                    r_idx[i] <= w_idx[2*i+1];
                end
            end
        end
    end

    assign o_found = r_vld[1];
    assign o_idx   = r_idx[1];
    assign o_size  = r_sz[1];

endmodule

[src/worst_fit_block_allocator_core.sv]
// Worst-fit block allocator. The block table is a row of MAX_BLOCKS cells;
// an allocation word is searched by a registered compare tree over all
// cells, log2(MAX_BLOCKS) levels deep, and the commit then shrinks the
// chosen block and inserts the remainder by moving every later cell up
// one place from its neighbor, all in the same commit. One word is worked
// on at a time: an append goes from idle straight to the commit, while an
// allocation first waits in the search state for the tree to settle. A
// new word is taken while the previous result still waits at the output.
// The table needs no clearing after reset; only the fill count and free-space total are cleared.
// ----------------------------------------------------------------------------
// worst_fit_block_allocator_core
// Top level: sequencer, fill count, free-space total and output register.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator_core #(
    parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wfba_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wfba_pkg::t_out_word o_out_word
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int DLY_W = $clog2(IDX_W + 1);
    localparam int SUM_W = wfba_pkg::SUM_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [DLY_W-1:0]     r_dly;
    logic                 r_mode;
    logic [SIZE_BITS-1:0] r_amount;
    logic                 r_used_flag;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [SUM_W-1:0]     r_free_sum;
    logic [SUM_W-1:0]     n_free_sum;
    logic                 r_out_valid;
    wfba_pkg::t_out_word  r_out_word;
    wfba_pkg::t_out_word  n_out_word;

    logic                 w_accept;
    logic                 w_commit;
    logic                 w_full;
    logic                 w_found;
    logic [IDX_W-1:0]     w_best;
    logic [SIZE_BITS-1:0] w_chosen;
    logic [SIZE_BITS-1:0] w_rem;
    logic                 w_split;
    logic                 w_ovf_split;
    wfba_pkg::t_cell_cmd  w_cmd;

    logic                 w_cand [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] w_size [MAX_BLOCKS];
    logic                 w_used [MAX_BLOCKS];

    // handshakes
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_commit    = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // search result and split decision
    assign w_full      = (r_count == CNT_W'(MAX_BLOCKS));
    assign w_rem       = w_chosen - r_amount;
    assign w_split     = w_found && (w_rem != '0) && !w_full;
    assign w_ovf_split = w_found && (w_rem != '0) && w_full;

    // command to the cells
    always_comb begin
        w_cmd           = '0;
        w_cmd.append    = (r_mode == wfba_pkg::MODE_APPEND) && !w_full;
        w_cmd.alloc_hit = (r_mode == wfba_pkg::MODE_ALLOC) && w_found;
        w_cmd.split     = (r_mode == wfba_pkg::MODE_ALLOC) && w_split;
        w_cmd.best      = wfba_pkg::IDX_MAX_W'(w_best);
        w_cmd.count     = wfba_pkg::CNT_MAX_W'(r_count);
        w_cmd.amount    = wfba_pkg::SIZE_MAX_W'(r_amount);
        w_cmd.rem       = wfba_pkg::SIZE_MAX_W'(w_rem);
        w_cmd.used_flag = r_used_flag;
    end

    // row of table cells, each fed by its lower neighbor
    for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
        logic [SIZE_BITS-1:0] w_prev_size;
        logic                 w_prev_used;
        if (k == 0) begin : g_first
            assign w_prev_size = '0;
            assign w_prev_used = 1'b0;
        end else begin : g_rest
            assign w_prev_size = w_size[k-1];
            assign w_prev_used = w_used[k-1];
        end
        wfba_cell #(
            .SIZE_W (SIZE_BITS),
            .POS    (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_cmd_en    (w_commit),
            .i_prev_size (w_prev_size),
            .i_prev_used (w_prev_used),
            .o_size      (w_size[k]),
            .o_used      (w_used[k]),
            .o_cand      (w_cand[k])
        );
    end

    // largest-free-block search
    wfba_max_tree #(
        .N      (MAX_BLOCKS),
        .SIZE_W (SIZE_BITS),
        .IDX_W  (IDX_W)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (w_cand),
        .i_size  (w_size),
        .o_found (w_found),
        .o_idx   (w_best),
        .o_size  (w_chosen)
    );

    // next count, free total and result word
    always_comb begin
        n_count    = r_count;
        n_free_sum = r_free_sum;
        n_out_word = '0;
        if (r_mode == wfba_pkg::MODE_APPEND) begin
            if (w_full) begin
                n_out_word.overflow = 1'b1;
            end else begin
                n_count                = r_count + CNT_W'(1);
                n_out_word.granted     = 1'b1;
                n_out_word.position    = wfba_pkg::POS_W'(r_count);
                n_out_word.chosen_size = wfba_pkg::AMOUNT_W'(r_amount);
                if (!r_used_flag) begin
                    n_free_sum = r_free_sum + SUM_W'(r_amount);
                end
            end
        end else if (w_found) begin
            n_out_word.granted     = 1'b1;
            n_out_word.position    = wfba_pkg::POS_W'(w_best);
            n_out_word.chosen_size = wfba_pkg::AMOUNT_W'(w_chosen);
            n_out_word.overflow    = w_ovf_split;
            if (w_split) begin
                n_count    = r_count + CNT_W'(1);
                n_free_sum = r_free_sum - SUM_W'(r_amount);
            end else begin
                n_free_sum = r_free_sum - SUM_W'(w_chosen);
            end
        end
        n_out_word.free_total  = n_free_sum;
        n_out_word.entry_count = wfba_pkg::COUNT_W'(n_count);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_word.mode == wfba_pkg::MODE_ALLOC) ? ST_SEARCH : ST_DONE;
                end
            end
            ST_SEARCH: begin
                if (r_dly == DLY_W'(IDX_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dly       <= '0;
            r_count     <= '0;
            r_free_sum  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SEARCH) begin
                r_dly <= r_dly + DLY_W'(1);
            end else begin
                r_dly <= '0;
            end
            if (w_commit) begin
                r_count     <= n_count;
                r_free_sum  <= n_free_sum;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // word and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode      <= i_in_word.mode;
            r_amount    <= SIZE_BITS'(i_in_word.amount);
            r_used_flag <= i_in_word.used_flag;
        end
        if (w_commit) begin
            r_out_word <= n_out_word;
        end
    end

    // table never holds more than its capacity
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count above capacity");

    // a dropped append leaves the table size alone
    a_drop_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (r_mode == wfba_pkg::MODE_APPEND) && w_full) |=> $stable(r_count))
        else $error("dropped append changed block count");

    // overflow is only reported with a full table
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.overflow)
            |-> (o_out_word.entry_count == wfba_pkg::COUNT_W'(MAX_BLOCKS)))
        else $error("overflow without full table");

    // a refused word carries no position or size
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.granted)
            |-> ((o_out_word.position == '0) && (o_out_word.chosen_size == '0)))
        else $error("refused word has nonzero position or size");

    // search result is only used after the tree has settled
    a_commit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> !w_commit)
        else $error("commit during search");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the worst-fit block allocator. A scoreboard class
// keeps its own copy of the block table, predicts the result word of every
// accepted input word and checks the result words in order. Stimulus is a
// short directed run followed by random words that are steered by the
// predicted table contents. Random idling happens on both channels.
// ----------------------------------------------------------------------------

// Block table predictor plus in-order result check
class alloc_scoreboard;
    bit [wfba_pkg::AMOUNT_W-1:0] blk_size [wfba_pkg::MAX_BLOCKS_DEF];
    bit                          blk_used [wfba_pkg::MAX_BLOCKS_DEF];
    int                          blk_count;
    bit [wfba_pkg::SUM_W-1:0]    free_space;
    wfba_pkg::t_out_word         pending [$];
    int                          mismatches;
    int                          n_checked, n_appends, n_grants, n_misses, n_overflows;

    // size of a random free block, -1 if there is none
    function int any_free_size();
        int picks [$];
        for (int j = 0; j < blk_count; j++)
            if (!blk_used[j]) picks.push_back(blk_size[j]);
        if (picks.size() == 0) return -1;
        return picks[$urandom_range(picks.size() - 1)];
    endfunction

    // largest free size, -1 if there is none
    function int largest_free();
        int top;
        top = -1;
        for (int j = 0; j < blk_count; j++)
            if (!blk_used[j] && int'(blk_size[j]) > top) top = blk_size[j];
        return top;
    endfunction

    // accepted input word: update the table and queue the expected result
    function void note_input(wfba_pkg::t_in_word w);
        wfba_pkg::t_out_word         r;
        int                          best;
        bit [wfba_pkg::AMOUNT_W-1:0] rem;
        r    = '0;
        best = -1;
        if (w.mode == wfba_pkg::MODE_APPEND) begin
            if (blk_count >= wfba_pkg::MAX_BLOCKS_DEF) begin
                r.overflow = 1'b1;
                n_overflows++;
            end else begin
                blk_size[blk_count] = w.amount;
                blk_used[blk_count] = w.used_flag;
                if (!w.used_flag) free_space += w.amount;
                r.granted     = 1'b1;
                r.position    = blk_count[wfba_pkg::POS_W-1:0];
                r.chosen_size = w.amount;
                blk_count++;
                n_appends++;
            end
        end else begin
            // largest fitting free block, lowest position on ties
            for (int j = 0; j < blk_count; j++)
                if (!blk_used[j] && blk_size[j] >= w.amount &&
                    (best < 0 || blk_size[j] > blk_size[best]))
                    best = j;
            if (best < 0) begin
                n_misses++;
            end else begin
                n_grants++;
                r.granted     = 1'b1;
                r.position    = best[wfba_pkg::POS_W-1:0];
                r.chosen_size = blk_size[best];
                rem = blk_size[best] - w.amount;
                blk_used[best] = 1'b1;
                if (rem == 0) begin
                    free_space -= blk_size[best];
                end else if (blk_count >= wfba_pkg::MAX_BLOCKS_DEF) begin
                    // no room for the remainder: whole block goes
                    free_space -= blk_size[best];
                    r.overflow = 1'b1;
                    n_overflows++;
                end else begin
                    for (int k = blk_count; k > best + 1; k--) begin
                        blk_size[k] = blk_size[k-1];
                        blk_used[k] = blk_used[k-1];
                    end
                    blk_size[best]   = w.amount;
                    blk_size[best+1] = rem;
                    blk_used[best+1] = 1'b0;
                    blk_count++;
                    free_space -= w.amount;
                end
            end
        end
        r.free_total  = free_space;
        r.entry_count = blk_count[wfba_pkg::COUNT_W-1:0];
        pending.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // accepted result word: compare with the oldest expectation
    function void check_result(wfba_pkg::t_out_word got);
        wfba_pkg::t_out_word want;
        n_checked++;
        if (pending.size() == 0) begin
            $error("result word with nothing expected: %h", got);
            mismatches++;
            return;
        end
        want = pending.pop_front();
        cmp_field("granted", 32'(want.granted), 32'(got.granted));
        cmp_field("position", 32'(want.position), 32'(got.position));
        cmp_field("chosen_size", 32'(want.chosen_size), 32'(got.chosen_size));
        cmp_field("free_total", 32'(want.free_total), 32'(got.free_total));
        cmp_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        cmp_field("overflow", 32'(want.overflow), 32'(got.overflow));
    endfunction
endclass

module testbench;
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    wfba_pkg::t_in_word  in_word   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    wfba_pkg::t_out_word out_word;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    alloc_scoreboard board = new();

    always #4 clk = ~clk;

    worst_fit_block_allocator_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // result side: check accepted words, random backpressure
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) board.check_result(out_word);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one word, return at the edge that accepts it
    task automatic send_word(input wfba_pkg::t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        board.note_input(w);
    endtask

    task automatic put(input logic mode, input int unsigned amount, input logic used);
        wfba_pkg::t_in_word w;
        w.mode      = mode;
        w.amount    = wfba_pkg::AMOUNT_W'(amount);
        w.used_flag = used;
        send_word(w);
    endtask

    // random word steered by the predicted table
    function automatic wfba_pkg::t_in_word make_word();
        wfba_pkg::t_in_word w;
        int                 pick, sz, top;
        pick        = $urandom_range(99);
        w.used_flag = 1'($urandom_range(1));
        // appends mostly while there is room, a few on a full table
        if ((board.blk_count < wfba_pkg::MAX_BLOCKS_DEF && pick < 30) || pick < 5) begin
            w.mode      = wfba_pkg::MODE_APPEND;
            w.amount    = ($urandom_range(3) == 0)
                        ? wfba_pkg::AMOUNT_W'($urandom_range(15))
                        : wfba_pkg::AMOUNT_W'($urandom);
            w.used_flag = ($urandom_range(3) == 0);
        end else begin
            w.mode = wfba_pkg::MODE_ALLOC;
            sz     = board.any_free_size();
            top    = board.largest_free();
            pick   = $urandom_range(99);
            if (sz < 0 || pick < 15)
                w.amount = wfba_pkg::AMOUNT_W'($urandom);
            else if (pick < 30)
                w.amount = wfba_pkg::AMOUNT_W'(sz);                   // exact fit
            else if (pick < 40)
                w.amount = '0;                                        // zero request
            else if (pick < 55 && top < 65535)
                w.amount = wfba_pkg::AMOUNT_W'($urandom_range(65535, top + 1)); // no fit
            else
                w.amount = wfba_pkg::AMOUNT_W'($urandom_range(sz));   // split
        end
        return w;
    endfunction

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 45;

        // directed: empty table, extremes, ties, zero sizes, splits
        put(wfba_pkg::MODE_ALLOC, 0, 1'b0);           // nothing to search
        put(wfba_pkg::MODE_ALLOC, 65535, 1'b1);
        put(wfba_pkg::MODE_APPEND, 65535, 1'b0);
        put(wfba_pkg::MODE_APPEND, 0, 1'b0);          // free block of size zero
        put(wfba_pkg::MODE_APPEND, 1000, 1'b1);       // starts used
        put(wfba_pkg::MODE_APPEND, 65535, 1'b0);      // ties with position 0
        put(wfba_pkg::MODE_ALLOC, 65535, 1'b0);       // tie goes low, exact fit
        put(wfba_pkg::MODE_ALLOC, 0, 1'b1);           // zero request splits whole size off
        put(wfba_pkg::MODE_ALLOC, 65535, 1'b0);
        put(wfba_pkg::MODE_ALLOC, 1, 1'b0);           // only a zero block left: no fit
        put(wfba_pkg::MODE_ALLOC, 0, 1'b0);           // zero block taken, no split
        put(wfba_pkg::MODE_APPEND, 500, 1'b0);
        put(wfba_pkg::MODE_ALLOC, 200, 1'b0);         // split, remainder inserted
        put(wfba_pkg::MODE_APPEND, 16'h5555, 1'b0);
        put(wfba_pkg::MODE_APPEND, 16'hAAAA, 1'b1);
        put(wfba_pkg::MODE_ALLOC, 16'h5554, 1'b1);
        put(wfba_pkg::MODE_ALLOC, 16'h5556, 1'b0);
        put(wfba_pkg::MODE_ALLOC, 300, 1'b0);
        put(wfba_pkg::MODE_ALLOC, 1, 1'b0);

        // random: three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 18; recv_idle_pct = 45; end
                1: begin send_idle_pct = 45; recv_idle_pct = 18; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            repeat (500) send_word(make_word());
        end
        in_valid <= 1'b0;

        // drain, then a few cycles for anything stray
        while (board.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d result words checked: %0d appends taken, %0d allocations granted,",
                 board.n_checked, board.n_appends, board.n_grants);
        $display("%0d requests without a fit, %0d full-table overflows, %0d blocks at end",
                 board.n_misses, board.n_overflows, board.blk_count);
        if (board.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
